// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL; they compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked at every rising edge of clk_i outside reset.
`define QPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define QPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define QPD_ASSERT(lbl, prop, msg)
`define QPD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/qpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Quoted-printable decoder package
// Character constants, the decoder state type and the hex digit function.
// ----------------------------------------------------------------------------
package qpd_pkg;

  localparam logic [7:0] CharEq      = 8'h3D;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharLf      = 8'h0A;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] LetterBias  = 8'd55;

  typedef struct packed {
    logic [7:0] prev_char;
    logic [7:0] prev_prev_char;
    logic       skipping_line;
  } qpd_state_t;

  localparam qpd_state_t StateReset = '{
    prev_char:      CharSpace,
    prev_prev_char: CharSpace,
    skipping_line:  1'b0
  };

  // A digit is c - '0' for '0'..'9' and c - 55 for any other byte, modulo 256.
  // The full byte is kept because the low digit is added without masking.
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c >= CharZero && c <= CharNine) begin
      return c - CharZero;
    end
    return c - LetterBias;
  endfunction

endpackage

// ===== rtl/qpd_step.sv =====
// ----------------------------------------------------------------------------
// Quoted-printable decoder step
// Combinational next-state and result logic for one encoded byte.
// ----------------------------------------------------------------------------
module qpd_step (
  input  qpd_pkg::qpd_state_t state_i,
  input  logic [7:0]          data_byte_i,
  input  logic                start_of_message_i,
  output qpd_pkg::qpd_state_t state_o,
  output logic                emit_o,
  output logic [7:0]          out_byte_o
);
  import qpd_pkg::*;

  qpd_state_t cur;
  logic       is_break;
  logic [7:0] hi_val;
  logic [7:0] lo_val;

  assign cur      = start_of_message_i ? StateReset : state_i;
  assign is_break = (data_byte_i == CharSpace) || (data_byte_i == CharTab) ||
                    (data_byte_i == CharCr);
  assign hi_val   = digit_value(cur.prev_char);
  assign lo_val   = digit_value(data_byte_i);

  always_comb begin
    state_o    = cur;
    emit_o     = 1'b0;
    out_byte_o = data_byte_i;
    priority if (cur.skipping_line) begin
      if (data_byte_i == CharLf) begin
        state_o = '{prev_char: CharLf, prev_prev_char: CharSpace, skipping_line: 1'b0};
      end
    end else if (data_byte_i == CharEq) begin
      state_o.prev_prev_char = cur.prev_char;
      state_o.prev_char      = data_byte_i;
    end else if (cur.prev_char == CharEq) begin
      if (is_break) begin
        state_o = '{prev_char: CharSpace, prev_prev_char: CharSpace, skipping_line: 1'b1};
      end else begin
        state_o.prev_prev_char = cur.prev_char;
        state_o.prev_char      = data_byte_i;
      end
    end else if (cur.prev_prev_char == CharEq) begin
      // Only the low nibble of the high digit survives the shift; the low
      // digit is added in full and the sum wraps at eight bits.
      emit_o                 = 1'b1;
      out_byte_o             = {hi_val[3:0], 4'h0} + lo_val;
      state_o.prev_prev_char = CharSpace;
      state_o.prev_char      = data_byte_i;
    end else begin
      emit_o                 = 1'b1;
      state_o.prev_prev_char = cur.prev_char;
      state_o.prev_char      = data_byte_i;
    end
  end

endmodule

// ===== rtl/quoted_printable_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Quoted-printable decoder
// Streams encoded bytes in and decoded bytes out, one byte per cycle while the output side takes its results.
// ----------------------------------------------------------------------------
// The decoder takes one byte of quoted-printable text per transfer and gives
// zero or one decoded byte for it. It sustains one input transfer per clock
// cycle while the output side takes its results; a byte that decodes to a
// result is held in the input register, is then written to the output
// register and is offered on the output from there. The rate is set by the
// single decode step between those two registers, which also updates the
// two-byte history and the soft-break flag in the same cycle. An '=' opens an
// escape, the next two bytes form one decoded byte, and an '=' followed by
// space, tab or CR drops everything up to and including the next LF. Raising
// start_of_message_i with a byte clears the history and the soft-break flag
// before that byte is decoded. The input side keeps accepting while a
// finished byte waits on the output, as long as the item already in the
// input register can move on.
module quoted_printable_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_of_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o
);
  import qpd_pkg::*;

  `include "assert_macros.svh"

  // Input register stage.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_sop_q;

  // Decoder state and output register.
  qpd_state_t state_q, state_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;

  logic       step_emit;
  logic [7:0] step_byte;
  logic       out_free;
  logic       s1_adv;
  logic       in_xfer;

  qpd_step u_step (
    .state_i           (state_q),
    .data_byte_i       (s1_byte_q),
    .start_of_message_i(s1_sop_q),
    .state_o           (state_d),
    .emit_o            (step_emit),
    .out_byte_o        (step_byte)
  );

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_ready_i;
  // A byte that gives no result moves on regardless of the output side.
  assign s1_adv   = s1_valid_q && (!step_emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= data_byte_i;
      s1_sop_q  <= start_of_message_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        state_q <= state_d;
      end
      if (s1_adv && step_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && step_emit) begin
      out_byte_q <= step_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  // A soft break can only begin right after an '=' in the history.
  `QPD_ASSERT(a_skip_after_eq,
              $rose(state_q.skipping_line) |-> $past(state_q.prev_char == CharEq),
              "soft break without a preceding equals sign")
  // While dropping a line the history holds space.
  `QPD_ASSERT(a_skip_history,
              state_q.skipping_line |-> (state_q.prev_char == CharSpace),
              "history changed while skipping a line")
  // A result is never written over one that is still waiting.
  `QPD_ASSERT_NEVER(a_no_overwrite,
                    s1_adv && step_emit && out_valid_q && !out_ready_i,
                    "decoded byte overwrote a pending result")
  // An empty input register always takes a new transfer.
  `QPD_ASSERT(a_ready_when_empty, !s1_valid_q |-> in_ready_o, "input stalled while empty")

endmodule
